### rtl/pacc_pkg.sv
// types, constants and helper functions shared by the polar angle correction block
package pacc_pkg;

	localparam int CORDIC_ZW = 34;
	localparam int ROT_W = 34;
	localparam int VEC_W = 42;
	localparam int DEN_W = 34;
	localparam int DIV_W = 58;
	localparam int QUO_W = 24;
	localparam int LIN_W = 40;
	localparam int DLT_W = 48;

	localparam logic signed [ROT_W-1:0] KINV_Q30 = ROT_W'(652032875);
	localparam logic signed [VEC_W-1:0] GAIN_Q30 = VEC_W'(1768195373);
	localparam longint PI180_Q32 = 74961321;
	localparam longint DEG_Q24 = 961263667;

	localparam longint ATAN_HEAD [10] = '{
		843314857, 497837829, 263043837, 133525159, 67021687,
		33543516, 16775851, 8388437, 4194283, 2097149
	};

	typedef enum logic [2:0] {
		CFG_ANGLE_A_OFFSET = 3'd0,
		CFG_ANGLE_B_OFFSET = 3'd1,
		CFG_COEF_CONSTANT  = 3'd2,
		CFG_COEF_LINEAR    = 3'd3,
		CFG_COEF_SQUARE    = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic signed [15:0] angle_a;
		logic signed [15:0] angle_b;
		logic signed [23:0] position_x;
	} evt_item_t;

	typedef struct packed {
		logic signed [23:0] corrected_x;
		logic [14:0]        polar_angle;
		logic               saturated;
	} res_item_t;

	// control and sideband that travels with each beat down the chain
	typedef struct packed {
		logic               vld;
		logic               flag;
		logic signed [23:0] px;
	} side_t;

	// micro-rotation angle of step i, radians Q2.30
	function automatic logic signed [CORDIC_ZW-1:0] atan_step(input int i);
		logic signed [CORDIC_ZW-1:0] r;
		if (i < 10) begin
			r = CORDIC_ZW'(ATAN_HEAD[i]);
		end else if (i <= 30) begin
			r = CORDIC_ZW'(longint'(1) << (30 - i));
		end else begin
			r = '0;
		end
		return r;
	endfunction

endpackage

### rtl/polar_angle_position_correction.sv
// polar angle from two track angles and quadratic correction of the x position
//
// Usage: one event beat (angle_a, angle_b, position_x) on evt with evt_valid and
// evt_ready; one result beat (corrected_x, polar_angle, saturated) on res with
// res_valid and res_ready for every event, in order. Registers are to be written
// through cfg (cfg_index, cfg_data) only while no event is in flight; the block does
// not enforce this. cfg_ready is always high and an unknown index is ignored.
// Path: the result reaches the output register through angle reduction, two
// rotation cordic chains for sin/cos, a 24-cell divider chain for the tangents,
// two vectoring cordic chains, and the theta scale and polynomial stages.
// Throughput: one event per cycle while not stalled; every cell hands its beat
// on each cycle the chain advances. A stalled receiver (res_valid high, res_ready
// low) freezes the whole chain and drops evt_ready in the same cycle; nothing is
// lost and the chain resumes when the result beat is taken.
// Reset: the chain empties, res_valid goes low, registers take their defaults.
module polar_angle_position_correction import pacc_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = 8,
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        evt_valid,
	output logic        evt_ready,
	input  evt_item_t   evt,
	output logic        res_valid,
	input  logic        res_ready,
	output res_item_t   res,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int F = ANGLE_FRAC_BITS;
	localparam int N = CORDIC_ITERATIONS;
	localparam longint PER = longint'(180) << F;
	localparam longint HALF = longint'(90) << F;
	localparam longint OFFS = PER * ((65536 + PER - 1) / PER);
	localparam int UW = $clog2(OFFS + 65536);
	localparam int SH = 40;
	localparam longint RECIP = (longint'(1) << SH) / PER;
	localparam int RW = $clog2(RECIP + 1);
	localparam int PW = UW + RW;
	localparam int MW = $clog2(HALF + 1);
	localparam int TW = F + 7;
	localparam int PTW = 61;
	localparam int P2W = 32 + TW + 1;
	localparam int PHW = 17 + TW;
	localparam int PLW = 24 + TW;
	localparam int FW = LIN_W + TW + 1;
	localparam int CW = DLT_W + 2;

	// configuration registers
	logic signed [15:0] off_a_q;
	logic signed [15:0] off_b_q;
	logic signed [31:0] coef_c_q;
	logic signed [31:0] coef_l_q;
	logic signed [31:0] coef_s_q;

	logic adv;

	// angle reduction stages
	logic signed [16:0] ang_c [2];
	logic [UW-1:0]      u_s1 [2];
	logic [UW-1:0]      u_s2 [2];
	logic [PW-1:0]      prod_s2 [2];
	logic [UW-1:0]      r_s3 [2];
	logic [MW-1:0]      m_s4 [2];
	logic signed [CORDIC_ZW-1:0] z_s5 [2];
	side_t side_s1, side_s2, side_s3, side_s4, side_s5;

	// rotation chains
	logic signed [ROT_W-1:0]     rx [2][N+1];
	logic signed [ROT_W-1:0]     ry [2][N+1];
	logic signed [CORDIC_ZW-1:0] rz [2][N+1];
	side_t                       rs [2][N+1];

	// divider chains
	logic [DIV_W-1:0] dr [2][QUO_W+1];
	logic [DEN_W-1:0] dd [2][QUO_W+1];
	logic [QUO_W-1:0] dq [2][QUO_W+1];
	side_t            ds [2][QUO_W+1];
	logic [QUO_W:0]   tan_c [2];

	// vectoring chains
	logic signed [VEC_W-1:0]     v1x [N+1];
	logic signed [VEC_W-1:0]     v1y [N+1];
	logic signed [CORDIC_ZW-1:0] v1z [N+1];
	side_t                       v1s [N+1];
	logic signed [VEC_W-1:0]     v2x [N+1];
	logic signed [VEC_W-1:0]     v2y [N+1];
	logic signed [CORDIC_ZW-1:0] v2z [N+1];
	side_t                       v2s [N+1];

	// theta and polynomial stages
	logic [30:0]              zc_c;
	logic [PTW-1:0]           prod_sc;
	logic [PTW:0]             tfull_c;
	logic [TW-1:0]            t_sd, t_se, t_sf, t_sg, t_sh;
	logic signed [P2W-1:0]    pc2_se;
	logic signed [LIN_W-1:0]  lin_sf;
	logic signed [PHW-1:0]    phi_sg;
	logic [PLW-1:0]           plo_sg;
	logic signed [FW-1:0]     full_c;
	logic signed [DLT_W-1:0]  delta_sh;
	logic signed [CW-1:0]     corr_c;
	logic                     hi_c, lo_c;
	side_t side_sc, side_sd, side_se, side_sf, side_sg, side_sh;

	// configuration port
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_a_q <= 16'sd1050;
			off_b_q <= 16'sd51;
			coef_c_q <= -32'sd572568;
			coef_l_q <= 32'sd1521;
			coef_s_q <= 32'sd27940;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ANGLE_A_OFFSET: off_a_q <= cfg_data[15:0];
				CFG_ANGLE_B_OFFSET: off_b_q <= cfg_data[15:0];
				CFG_COEF_CONSTANT:  coef_c_q <= cfg_data;
				CFG_COEF_LINEAR:    coef_l_q <= cfg_data;
				CFG_COEF_SQUARE:    coef_s_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// the whole chain moves unless a finished result waits
	assign adv = !res_valid || res_ready;
	assign evt_ready = adv;

	assign ang_c[0] = 17'(off_a_q) - 17'(evt.angle_a);
	assign ang_c[1] = 17'(evt.angle_b) + 17'(off_b_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
			side_s2 <= '0;
			side_s3 <= '0;
			side_s4 <= '0;
			side_s5 <= '0;
		end else if (adv) begin
			side_s1 <= '{vld: evt_valid, flag: 1'b0, px: evt.position_x};
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
			side_s5 <= side_s4;
		end
	end

	for (genvar c = 0; c < 2; c++) begin : g_ang
		logic [UW-1:0] r1_c;
		logic [DEN_W-1:0] ax_c, ay_c;
		logic clip_c;

		// modulo 180 deg via reciprocal estimate, then one correction
		assign r1_c = (longint'(r_s3[c]) >= PER) ? UW'(longint'(r_s3[c]) - PER) : r_s3[c];

		always_ff @(posedge clk) begin
			if (adv) begin
				u_s1[c] <= UW'(longint'(ang_c[c]) + OFFS);
				u_s2[c] <= u_s1[c];
				prod_s2[c] <= PW'(u_s1[c]) * PW'(RECIP);
				r_s3[c] <= u_s2[c] - UW'(longint'(prod_s2[c][PW-1:SH]) * PER);
				m_s4[c] <= (longint'(r1_c) > HALF) ? MW'(PER - longint'(r1_c)) : MW'(r1_c);
				z_s5[c] <= CORDIC_ZW'((longint'(m_s4[c]) * PI180_Q32) >>> (F + 2));
			end
		end

		assign rx[c][0] = KINV_Q30;
		assign ry[c][0] = '0;
		assign rz[c][0] = z_s5[c];
		assign rs[c][0] = (c == 0) ? side_s5 : side_t'('0);

		for (genvar i = 0; i < N; i++) begin : g_rot
			pacc_cordic_cell #(.W(ROT_W), .IDX(i), .ROTATE(1'b1)) u_cell (
				.clk(clk), .arst_n(arst_n), .en(adv),
				.x_i(rx[c][i]), .y_i(ry[c][i]), .z_i(rz[c][i]), .side_i(rs[c][i]),
				.x_o(rx[c][i+1]), .y_o(ry[c][i+1]), .z_o(rz[c][i+1]), .side_o(rs[c][i+1])
			);
		end

		// tangent magnitude: clip when cos is zero or |tan| reaches 256
		assign ax_c = DEN_W'(rx[c][N][ROT_W-1] ? -rx[c][N] : rx[c][N]);
		assign ay_c = DEN_W'(ry[c][N][ROT_W-1] ? -ry[c][N] : ry[c][N]);
		assign clip_c = (ax_c == '0) || ({8'b0, ay_c} >= {ax_c, 8'b0});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ds[c][0] <= '0;
			end else if (adv) begin
				ds[c][0] <= (c == 0)
					? side_t'{vld: rs[0][N].vld, flag: clip_c, px: rs[0][N].px}
					: side_t'{vld: 1'b0, flag: clip_c, px: '0};
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dr[c][0] <= DIV_W'(ay_c) << 16;
				dd[c][0] <= ax_c;
			end
		end

		assign dq[c][0] = '0;

		for (genvar j = 0; j < QUO_W; j++) begin : g_div
			pacc_div_cell #(.K(QUO_W - 1 - j)) u_cell (
				.clk(clk), .arst_n(arst_n), .en(adv),
				.rem_i(dr[c][j]), .den_i(dd[c][j]), .q_i(dq[c][j]), .side_i(ds[c][j]),
				.rem_o(dr[c][j+1]), .den_o(dd[c][j+1]), .q_o(dq[c][j+1]),
				.side_o(ds[c][j+1])
			);
		end

		assign tan_c[c] = ds[c][QUO_W].flag ? {1'b1, {QUO_W{1'b0}}} : {1'b0, dq[c][QUO_W]};
	end

	// first vectoring chain: magnitude of (tan a', tan b')
	assign v1x[0] = $signed(VEC_W'({tan_c[0], 14'b0}));
	assign v1y[0] = $signed(VEC_W'({tan_c[1], 14'b0}));
	assign v1z[0] = '0;
	assign v1s[0] = '{vld: ds[0][QUO_W].vld, flag: ds[0][QUO_W].flag | ds[1][QUO_W].flag,
		px: ds[0][QUO_W].px};

	for (genvar i = 0; i < N; i++) begin : g_vec1
		pacc_cordic_cell #(.W(VEC_W), .IDX(i), .ROTATE(1'b0)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.x_i(v1x[i]), .y_i(v1y[i]), .z_i(v1z[i]), .side_i(v1s[i]),
			.x_o(v1x[i+1]), .y_o(v1y[i+1]), .z_o(v1z[i+1]), .side_o(v1s[i+1])
		);
	end

	// second vectoring chain: atan of magnitude against the cordic gain
	assign v2x[0] = GAIN_Q30;
	assign v2y[0] = v1x[N][VEC_W-1] ? '0 : v1x[N];
	assign v2z[0] = '0;
	assign v2s[0] = v1s[N];

	for (genvar i = 0; i < N; i++) begin : g_vec2
		pacc_cordic_cell #(.W(VEC_W), .IDX(i), .ROTATE(1'b0)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.x_i(v2x[i]), .y_i(v2y[i]), .z_i(v2z[i]), .side_i(v2s[i]),
			.x_o(v2x[i+1]), .y_o(v2y[i+1]), .z_o(v2z[i+1]), .side_o(v2s[i+1])
		);
	end

	// radians to angle units with rounding, then clamp to 90 deg
	assign zc_c = v2z[N][CORDIC_ZW-1] ? '0 : v2z[N][30:0];
	assign tfull_c = (PTW'(prod_sc) + (PTW'(1) << (53 - F))) >> (54 - F);

	assign full_c = (FW'(phi_sg) <<< 24) + FW'($signed({1'b0, plo_sg}));
	assign corr_c = ((CW'(side_sh.px) <<< 8) - CW'(delta_sh) + CW'(128)) >>> 8;
	assign hi_c = corr_c > CW'(8388607);
	assign lo_c = corr_c < -CW'(8388608);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_sc <= '0;
			side_sd <= '0;
			side_se <= '0;
			side_sf <= '0;
			side_sg <= '0;
			side_sh <= '0;
			res_valid <= 1'b0;
		end else if (adv) begin
			side_sc <= v2s[N];
			side_sd <= side_sc;
			side_se <= side_sd;
			side_sf <= side_se;
			side_sg <= side_sf;
			side_sh <= side_sg;
			res_valid <= side_sh.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_sc <= PTW'(zc_c) * PTW'(DEG_Q24);
			t_sd <= (tfull_c > (PTW + 1)'(HALF)) ? TW'(HALF) : TW'(tfull_c);
			pc2_se <= P2W'(coef_s_q) * P2W'($signed({1'b0, t_sd}));
			t_se <= t_sd;
			lin_sf <= LIN_W'(P2W'(coef_l_q) + (pc2_se >>> F));
			t_sf <= t_se;
			// signed upper part of lin times theta
			phi_sg <= PHW'($signed(lin_sf[LIN_W-1:24])) * PHW'($signed({1'b0, t_sf}));
			plo_sg <= PLW'(lin_sf[23:0]) * PLW'(t_sf);
			t_sg <= t_sf;
			delta_sh <= DLT_W'(FW'(coef_c_q) + (full_c >>> F));
			t_sh <= t_sg;
			res.corrected_x <= hi_c ? 24'sh7FFFFF : (lo_c ? 24'sh800000 : corr_c[23:0]);
			res.polar_angle <= 15'(t_sh);
			res.saturated <= side_sh.flag || hi_c || lo_c;
		end
	end

	// folded angle never exceeds a quarter turn
	assert property (@(posedge clk) disable iff (!arst_n)
		side_s4.vld |-> (m_s4[0] <= MW'(HALF)) && (m_s4[1] <= MW'(HALF)))
		else $error("folded angle above 90 deg");

	// an unclipped tangent leaves a remainder below the divisor
	assert property (@(posedge clk) disable iff (!arst_n)
		ds[0][QUO_W].vld && !ds[0][QUO_W].flag |-> dr[0][QUO_W] < DIV_W'(dd[0][QUO_W]))
		else $error("divider remainder not below divisor");

	// theta stays clamped to 90 deg
	assert property (@(posedge clk) disable iff (!arst_n)
		side_sd.vld |-> t_sd <= TW'(HALF))
		else $error("theta above 90 deg");

endmodule

### rtl/pacc_cordic_cell.sv
// one registered cordic micro-rotation cell, rotation or vectoring mode
module pacc_cordic_cell import pacc_pkg::*; #(
	parameter int W = 34,
	parameter int IDX = 0,
	parameter bit ROTATE = 1'b1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic signed [W-1:0]         x_i,
	input  logic signed [W-1:0]         y_i,
	input  logic signed [CORDIC_ZW-1:0] z_i,
	input  side_t                       side_i,
	output logic signed [W-1:0]         x_o,
	output logic signed [W-1:0]         y_o,
	output logic signed [CORDIC_ZW-1:0] z_o,
	output side_t                       side_o
);

	localparam logic signed [CORDIC_ZW-1:0] STEP = atan_step(IDX);

	logic                        dir;
	logic signed [W-1:0]         xs;
	logic signed [W-1:0]         ys;
	logic signed [W-1:0]         x_q;
	logic signed [W-1:0]         y_q;
	logic signed [CORDIC_ZW-1:0] z_q;
	side_t                       side_q;

	assign xs = x_i >>> IDX;
	assign ys = y_i >>> IDX;
	// rotate toward z = 0, or toward y = 0 when vectoring
	assign dir = ROTATE ? !z_i[CORDIC_ZW-1] : (y_i[W-1] || (y_i == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= '0;
		end else if (en) begin
			side_q <= side_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (dir) begin
				x_q <= x_i - ys;
				y_q <= y_i + xs;
				z_q <= z_i - STEP;
			end else begin
				x_q <= x_i + ys;
				y_q <= y_i - xs;
				z_q <= z_i + STEP;
			end
		end
	end

	assign x_o = x_q;
	assign y_o = y_q;
	assign z_o = z_q;
	assign side_o = side_q;

endmodule

### rtl/pacc_div_cell.sv
// one registered restoring division cell, resolves one quotient bit
module pacc_div_cell import pacc_pkg::*; #(
	parameter int K = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [DIV_W-1:0] rem_i,
	input  logic [DEN_W-1:0] den_i,
	input  logic [QUO_W-1:0] q_i,
	input  side_t            side_i,
	output logic [DIV_W-1:0] rem_o,
	output logic [DEN_W-1:0] den_o,
	output logic [QUO_W-1:0] q_o,
	output side_t            side_o
);

	logic [DIV_W-1:0] dsh;
	logic             ge;
	logic [DIV_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [QUO_W-1:0] q_q;
	side_t            side_q;

	assign dsh = DIV_W'(den_i) << K;
	assign ge = rem_i >= dsh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= '0;
		end else if (en) begin
			side_q <= side_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= ge ? rem_i - dsh : rem_i;
			den_q <= den_i;
			q_q <= {q_i[QUO_W-2:0], ge};
		end
	end

	assign rem_o = rem_q;
	assign den_o = den_q;
	assign q_o = q_q;
	assign side_o = side_q;

endmodule

### dv/tb_top.sv
// self-checking testbench for the polar angle and x position correction block
`timescale 1ns / 100ps

module tb_top;
	import pacc_pkg::*;

	localparam int FRAC = 8;
	localparam int ITERS = 16;
	localparam int PIPE_CYCLES = 3 * ITERS + 37;
	localparam longint RUN_LIMIT = 600000;
	localparam logic [2:0] CFG_UNUSED_IDX = 3'd5;
	localparam longint TAN_CLIP = longint'(1) << 24;
	localparam longint DEG90 = longint'(90) << FRAC;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        evt_valid = 1'b0;
	logic        evt_ready;
	evt_item_t   evt = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	res_item_t   res;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	// mirror of the block registers
	logic signed [15:0] ofs_a;
	logic signed [15:0] ofs_b;
	logic signed [31:0] c0;
	logic signed [31:0] c1;
	logic signed [31:0] c2;

	res_item_t pending_res[$];
	int        mismatches = 0;
	int        send_gap_pct = 0;
	int        recv_stall_pct = 0;
	int        hold_left = 0;
	longint    cycles = 0;

	polar_angle_position_correction #(
		.ANGLE_FRAC_BITS(FRAC),
		.CORDIC_ITERATIONS(ITERS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.evt_valid(evt_valid),
		.evt_ready(evt_ready),
		.evt(evt),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > RUN_LIMIT) begin
			$display("polar_angle_position_correction regression: fail");
			$finish;
		end
	end

	function automatic longint micro_angle(int i);
		longint r;
		if (i < 10) begin
			r = ATAN_HEAD[i];
		end else if (i <= 30) begin
			r = longint'(1) << (30 - i);
		end else begin
			r = 0;
		end
		return r;
	endfunction

	// q16.16 magnitude of tan, folded into 0..90 deg
	function automatic longint tan_q16(longint ang, inout bit clip);
		longint per, m, x, y, z, xs, ys, ax, ay;
		per = longint'(180) << FRAC;
		m = ang % per;
		x = longint'(KINV_Q30);
		y = 0;
		if (m < 0) begin
			m += per;
		end
		if (m > per / 2) begin
			m = per - m;
		end
		z = (m * PI180_Q32) >>> (FRAC + 2);
		for (int i = 0; i < ITERS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= micro_angle(i);
			end else begin
				x += ys; y -= xs; z += micro_angle(i);
			end
		end
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		if (ax == 0 || (ay << 16) >= TAN_CLIP * ax) begin
			clip = 1'b1;
			return TAN_CLIP;
		end
		return (ay << 16) / ax;
	endfunction

	function automatic res_item_t corrected_position(evt_item_t e);
		res_item_t r;
		bit clip;
		longint x1, y1, x2, y2, z, xs, ys, t, lin, delta, corr;
		clip = 1'b0;
		z = 0;
		x1 = tan_q16(longint'(ofs_a) - longint'(e.angle_a), clip) << 14;
		y1 = tan_q16(longint'(e.angle_b) + longint'(ofs_b), clip) << 14;
		for (int i = 0; i < ITERS; i++) begin
			xs = x1 >>> i;
			ys = y1 >>> i;
			if (y1 > 0) begin
				x1 += ys; y1 -= xs;
			end else begin
				x1 -= ys; y1 += xs;
			end
		end
		x2 = longint'(GAIN_Q30);
		y2 = (x1 < 0) ? 0 : x1;
		for (int i = 0; i < ITERS; i++) begin
			xs = x2 >>> i;
			ys = y2 >>> i;
			if (y2 > 0) begin
				x2 += ys; y2 -= xs; z += micro_angle(i);
			end else begin
				x2 -= ys; y2 += xs; z -= micro_angle(i);
			end
		end
		if (z < 0) begin
			z = 0;
		end
		t = (z * DEG_Q24 + (longint'(1) << (53 - FRAC))) >>> (54 - FRAC);
		if (t > DEG90) begin
			t = DEG90;
		end
		lin = longint'(c1) + ((longint'(c2) * t) >>> FRAC);
		delta = longint'(c0) + ((lin * t) >>> FRAC);
		corr = (longint'(e.position_x) * 256 - delta + 128) >>> 8;
		if (corr > 8388607) begin
			corr = 8388607; clip = 1'b1;
		end
		if (corr < -8388608) begin
			corr = -8388608; clip = 1'b1;
		end
		r.corrected_x = corr[23:0];
		r.polar_angle = t[14:0];
		r.saturated = clip;
		return r;
	endfunction

	// result side: check every beat, stall at random or for a hold-off
	always @(posedge clk) begin
		res_item_t want;
		if (res_valid && res_ready) begin
			if (pending_res.size() == 0) begin
				$error("result beat with nothing expected: %p", res);
				mismatches++;
			end else begin
				want = pending_res.pop_front();
				if (res.corrected_x !== want.corrected_x) begin
					$error("corrected_x expected %0d got %0d", want.corrected_x,
						res.corrected_x);
					mismatches++;
				end
				if (res.polar_angle !== want.polar_angle) begin
					$error("polar_angle expected %0d got %0d", want.polar_angle,
						res.polar_angle);
					mismatches++;
				end
				if (res.saturated !== want.saturated) begin
					$error("saturated expected %0d got %0d", want.saturated, res.saturated);
					mismatches++;
				end
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ready <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_event(evt_item_t e);
		evt_valid <= 1'b1;
		evt <= e;
		do @(posedge clk); while (!(evt_valid && evt_ready));
		pending_res.push_back(corrected_position(e));
		// idle cycles between beats, each with the given chance
		while ($urandom_range(99) < send_gap_pct) begin
			evt_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send_angles(int a, int b, int px);
		evt_item_t e;
		e.angle_a = 16'(a);
		e.angle_b = 16'(b);
		e.position_x = 24'(px);
		send_event(e);
	endtask

	task automatic drain;
		evt_valid <= 1'b0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (PIPE_CYCLES + 10) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		case (idx)
			CFG_ANGLE_A_OFFSET: ofs_a = val[15:0];
			CFG_ANGLE_B_OFFSET: ofs_b = val[15:0];
			CFG_COEF_CONSTANT:  c0 = val;
			CFG_COEF_LINEAR:    c1 = val;
			CFG_COEF_SQUARE:    c2 = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic load_regs(int oa, int ob, int k0, int k1, int k2);
		write_reg(CFG_ANGLE_A_OFFSET, 32'(oa));
		write_reg(CFG_ANGLE_B_OFFSET, 32'(ob));
		write_reg(CFG_COEF_CONSTANT, 32'(k0));
		write_reg(CFG_COEF_LINEAR, 32'(k1));
		write_reg(CFG_COEF_SQUARE, 32'(k2));
	endtask

	function automatic int rand_angle();
		int r;
		case ($urandom_range(9))
			0: r = $signed(16'($urandom));
			1: r = 23040 - $urandom_range(0, 300);
			default: r = $urandom_range(0, 46080) - 23040;
		endcase
		return r;
	endfunction

	task automatic random_events(int count);
		for (int i = 0; i < count; i++) begin
			send_angles(rand_angle(), rand_angle(), $signed(24'($urandom)));
		end
	endtask

	task automatic test_default_regs;
		send_angles(0, 0, 0);
		send_angles(1000, -500, 12345);
		send_angles(-23040, 23040, -8388608);
		send_angles(23040, -23040, 8388607);
		drain();
	endtask

	task automatic test_directed;
		load_regs(0, 0, 0, 0, 0);
		// straight through, theta zero
		send_angles(0, 0, 256);
		// exactly 90 deg: cos goes to zero, tangent clips
		send_angles(-23040, 0, 0);
		send_angles(0, 23040, 0);
		send_angles(-23040, -23040, -1);
		// beyond 90 deg folds back, and raw extremes of the fields
		send_angles(-32768, 32767, 8388607);
		send_angles(32767, -32768, -8388608);
		send_angles(-11520, 11520, 100);
		send_angles(-46080, 0, 5);
		send_angles(22900, 200, -77);
		drain();
		// huge negative correction pushes x past the top
		load_regs(0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_angles(-23040, 0, 8388607);
		send_angles(-5000, 3000, 8388000);
		send_angles(0, 0, 8388607);
		drain();
		// huge positive correction pulls x past the bottom
		load_regs(23040, -23040, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_angles(0, 0, -8388608);
		send_angles(5000, -1, -8000000);
		send_angles(23040, 23040, 0);
		drain();
		// out of range offsets and an ignored register index
		load_regs(-32768, 32767, -572568, 1521, 27940);
		write_reg(CFG_UNUSED_IDX, 32'hffff_ffff);
		send_angles(100, -100, 4000);
		send_angles(-32768, -32768, 1);
		drain();
	endtask

	task automatic test_random_regs(int rounds);
		for (int r = 0; r < rounds; r++) begin
			load_regs($urandom_range(0, 46080) - 23040, $urandom_range(0, 46080) - 23040,
				$urandom_range(0, 8000000) - 4000000, $urandom_range(0, 200000) - 100000,
				$urandom_range(0, 60000) - 30000);
			if (r % 2 == 1) begin
				write_reg(CFG_COEF_SQUARE, $urandom);
			end
			random_events(40);
			drain();
		end
	endtask

	task automatic test_idle_mixes;
		load_regs(1050, 51, -572568, 1521, 27940);
		send_gap_pct = 6;
		recv_stall_pct = 50;
		random_events(80);
		send_gap_pct = 50;
		recv_stall_pct = 6;
		random_events(80);
		send_gap_pct = 0;
		recv_stall_pct = 0;
		random_events(60);
		drain();
	endtask

	task automatic test_backpressure;
		hold_left = 400;
		random_events(120);
		drain();
	endtask

	initial begin
		ofs_a = 16'sd1050;
		ofs_b = 16'sd51;
		c0 = -32'sd572568;
		c1 = 32'sd1521;
		c2 = 32'sd27940;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_default_regs();
		test_directed();
		test_idle_mixes();
		test_backpressure();
		test_random_regs(4);
		if (mismatches == 0) begin
			$display("polar_angle_position_correction regression: pass");
		end else begin
			$display("polar_angle_position_correction regression: fail");
		end
		$finish;
	end

endmodule
